@@ src/pec_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pec_pkg;

    // longest escaped run: escape, 'x', four hex digits
    localparam int MAX_RUN   = 6;
    localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);

    localparam int CU_W      = 16;
    localparam int BYTE_W    = 8;
    localparam int MAP_W     = 64;
    localparam int MAP_WORDS = 4;
    localparam int CFG_IDX_W = 8;

    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h25;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ESCAPE_BYTE = 8'd0,
        CFG_ALLOW_MAP_0 = 8'd1,
        CFG_ALLOW_MAP_1 = 8'd2,
        CFG_ALLOW_MAP_2 = 8'd3,
        CFG_ALLOW_MAP_3 = 8'd4
    } cfg_reg_e;

    // one expanded run, byte 0 goes out first
    typedef struct packed {
        logic [MAX_RUN-1:0][BYTE_W-1:0] bytes;
        logic [RUN_CNT_W-1:0]           rem;
    } run_t;

endpackage

`default_nettype wire

@@ src/pec_channels.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pec_unit_if;
    import pec_pkg::*;
    logic            valid;
    logic            ready;
    logic [CU_W-1:0] code_unit;

    modport source (output valid, output code_unit, input ready);
    modport sink (input valid, input code_unit, output ready);
endinterface

interface pec_byte_if;
    import pec_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface pec_cfg_if;
    import pec_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [MAP_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/pec_expand.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pec_expand
    import pec_pkg::*;
(
    input  logic [CU_W-1:0]            code_unit,
    input  logic [BYTE_W-1:0]          escape_byte,
    input  logic [MAP_WORDS*MAP_W-1:0] allow_map,
    output run_t                       run
);

    function automatic logic [BYTE_W-1:0] hex_lower(input logic [3:0] nib);
        logic [BYTE_W-1:0] r;
        if (nib < 4'd10)
            r = 8'h30 + {4'd0, nib};
        else
            r = 8'h57 + {4'd0, nib};
        return r;
    endfunction

    function automatic logic is_alnum(input logic [BYTE_W-1:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a)
            || (b >= 8'h30 && b <= 8'h39);
    endfunction

    logic              short_unit;
    logic              raw;
    logic [BYTE_W-1:0] low_byte;

    assign low_byte   = code_unit[7:0];
    assign short_unit = (code_unit[15:8] == 8'd0) && (low_byte != 8'd0);
    assign raw        = short_unit && (is_alnum(low_byte) || allow_map[low_byte]);

    always_comb
    begin
        run.bytes = '0;
        if (raw)
        begin
            run.bytes[0] = low_byte;
            run.rem      = RUN_CNT_W'(1);
        end
        else if (short_unit)
        begin
            run.bytes[0] = escape_byte;
            run.bytes[1] = hex_lower(code_unit[7:4]);
            run.bytes[2] = hex_lower(code_unit[3:0]);
            run.rem      = RUN_CNT_W'(3);
        end
        else
        begin
            run.bytes[0] = escape_byte;
            run.bytes[1] = 8'h78;
            run.bytes[2] = hex_lower(code_unit[15:12]);
            run.bytes[3] = hex_lower(code_unit[11:8]);
            run.bytes[4] = hex_lower(code_unit[7:4]);
            run.bytes[5] = hex_lower(code_unit[3:0]);
            run.rem      = RUN_CNT_W'(MAX_RUN);
        end
    end

endmodule

`default_nettype wire

@@ src/percent_escape_encoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// percent escape encoder
// unit_ch takes one 16-bit code unit per item; byte_ch gives one byte per item,
// with last_of_run high on the final byte for that code unit
// letters, digits and allow-map bytes pass raw (1 byte); other units 1..255 give
// escape + two lowercase hex digits (3 bytes); zero or units above 255 give
// escape, 'x' and four hex digits (6 bytes)
// cfg_ch writes escape_byte (index 0) and allow_map_0..3 (index 1..4), always
// ready; other indexes are dropped; write only while the block is idle
// path: an accepted code unit is held in the run register, and its first byte then
// moves into the output register once that is empty or its byte is taken
// throughput: one output byte per cycle while byte_ch.ready is high; the run
// register empties one byte at a time and takes the next code unit in the same
// cycle its last byte moves out
// reset: escape byte is '%', allow map is clear, both channels empty
// stall: the output register holds while byte_ch.ready is low, the run
// register holds its remaining bytes, and unit_ch.ready drops while it holds any
module percent_escape_encoder_core
    import pec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pec_unit_if.sink    unit_ch,
    pec_byte_if.source  byte_ch,
    pec_cfg_if.sink     cfg_ch
);

    // configuration registers
    logic [BYTE_W-1:0]                escape_reg;
    logic [MAP_WORDS-1:0][MAP_W-1:0]  allow_reg;

    // run register: bytes still to send for the current code unit
    logic  run_valid_reg;
    run_t  run_reg;
    run_t  run_next;

    // output register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    logic unit_take;
    logic out_load;
    logic run_done;
    cfg_reg_e cfg_sel;

    assign cfg_sel = cfg_reg_e'(cfg_ch.index);

    // expansion of the incoming code unit
    pec_expand u_expand (
        .code_unit   (unit_ch.code_unit),
        .escape_byte (escape_reg),
        .allow_map   (allow_reg),
        .run         (run_next)
    );

    // output register moves on when empty or when its byte is taken
    assign out_load = run_valid_reg && (!out_valid_reg || byte_ch.ready);
    assign run_done = out_load && (run_reg.rem == RUN_CNT_W'(1));

    // a new code unit enters when the run register is empty or sends its last byte
    assign unit_ch.ready = !run_valid_reg || run_done;
    assign unit_take     = unit_ch.valid && unit_ch.ready;

    assign cfg_ch.ready = 1'b1;

    assign byte_ch.valid       = out_valid_reg;
    assign byte_ch.out_byte    = out_byte_reg;
    assign byte_ch.last_of_run = out_last_reg;

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg    <= ESCAPE_RESET;
            allow_reg     <= '0;
            run_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                unique case (cfg_sel)
                    CFG_ESCAPE_BYTE: escape_reg   <= cfg_ch.data[BYTE_W-1:0];
                    CFG_ALLOW_MAP_0: allow_reg[0] <= cfg_ch.data;
                    CFG_ALLOW_MAP_1: allow_reg[1] <= cfg_ch.data;
                    CFG_ALLOW_MAP_2: allow_reg[2] <= cfg_ch.data;
                    CFG_ALLOW_MAP_3: allow_reg[3] <= cfg_ch.data;
                    default: ; // unknown index, write dropped
                endcase
            end

            if (unit_take)
                run_valid_reg <= 1'b1;
            else if (run_done)
                run_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (byte_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (unit_take)
            run_reg <= run_next;
        else if (out_load)
        begin
            // shift the run down one byte
            run_reg.bytes <= {{BYTE_W{1'b0}}, run_reg.bytes[MAX_RUN-1:1]};
            run_reg.rem   <= run_reg.rem - RUN_CNT_W'(1);
        end

        if (out_load)
        begin
            out_byte_reg <= run_reg.bytes[0];
            out_last_reg <= (run_reg.rem == RUN_CNT_W'(1));
        end
    end

    // a code unit only enters when at most the last byte of a run is pending
    a_ready_only_at_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        unit_ch.ready |-> (!run_valid_reg || run_reg.rem == RUN_CNT_W'(1)))
        else $error("unit accepted while run has bytes left");

    // a held run always has between one and six bytes
    a_run_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> (run_reg.rem != '0 && run_reg.rem <= RUN_CNT_W'(MAX_RUN)))
        else $error("run length out of range");

    // the last flag follows the run count of the byte loaded
    a_last_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_last_reg == $past(run_reg.rem == RUN_CNT_W'(1))))
        else $error("last_of_run does not match run count");

    // an accepted code unit is held in the run register next cycle
    a_take_fills_run: assert property (@(posedge clk) disable iff (!rst_n)
        unit_take |=> run_valid_reg)
        else $error("accepted code unit lost");

endmodule

`default_nettype wire

@@ sim/tb_percent_escape_encoder_core.sv @@
`timescale 1ns / 1ps

module tb_percent_escape_encoder_core;
    import pec_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 3;
    // extra wait after the encoder drains, before touching the registers
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int RANDOM_PER_PHASE = 24;

    // register indexes past the last one; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = CFG_ALLOW_MAP_3 + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = '1;

    // characters the encoder treats specially
    localparam logic [BYTE_W-1:0] CH_LOWER_A = "a";
    localparam logic [BYTE_W-1:0] CH_LOWER_Z = "z";
    localparam logic [BYTE_W-1:0] CH_UPPER_A = "A";
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = "Z";
    localparam logic [BYTE_W-1:0] CH_DIGIT_0 = "0";
    localparam logic [BYTE_W-1:0] CH_DIGIT_9 = "9";
    localparam logic [BYTE_W-1:0] CH_X       = "x";

    localparam logic [MAP_W-1:0] MAP_NONE = '0;
    localparam logic [MAP_W-1:0] MAP_ALL  = '1;

    // one byte of an encoded run as it should come out
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              is_last;
    } enc_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    pec_unit_if unit_ch ();
    pec_byte_if byte_ch ();
    pec_cfg_if  cfg_ch ();

    percent_escape_encoder_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .unit_ch (unit_ch),
        .byte_ch (byte_ch),
        .cfg_ch  (cfg_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // code units still to be offered, and bytes the encoder still owes
    logic [CU_W-1:0] unit_queue [$];
    enc_byte_t       expected_bytes [$];

    // predictor copy of the registers
    logic [BYTE_W-1:0] esc_model;
    logic [MAP_W-1:0]  allow_model [MAP_WORDS];

    // idling knobs, changed only between phases
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    // long output hold-off, requested by the stimulus and counted by the ready process
    int unsigned hold_asked = 0;
    int unsigned hold_taken = 0;
    int unsigned hold_left  = 0;

    logic        unit_fire = 1'b0;
    enc_byte_t   want_byte;
    int unsigned n_errors  = 0;
    int unsigned n_units   = 0;
    int unsigned n_bytes   = 0;
    int unsigned n_raw     = 0;
    int unsigned n_short   = 0;
    int unsigned n_long    = 0;
    int unsigned n_writes  = 0;
    int unsigned n_stalled = 0;
    int unsigned cycle_count = 0;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nibble);
        return (nibble < 4'd10) ? CH_DIGIT_0 + BYTE_W'(nibble)
                                : CH_LOWER_A + BYTE_W'(nibble) - BYTE_W'(10);
    endfunction

    // letters and digits always pass; anything else only through the allow map
    function automatic logic passes_raw(input logic [BYTE_W-1:0] b);
        if (b >= CH_LOWER_A && b <= CH_LOWER_Z)
            return 1'b1;
        if (b >= CH_UPPER_A && b <= CH_UPPER_Z)
            return 1'b1;
        if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9)
            return 1'b1;
        return allow_model[b[7:6]][b[5:0]];
    endfunction

    function automatic enc_byte_t enc(input logic [BYTE_W-1:0] v, input logic l);
        enc_byte_t e;
        e.value   = v;
        e.is_last = l;
        return e;
    endfunction

    // append one owed byte
    task automatic owe_byte(input logic [BYTE_W-1:0] v, input logic l);
        expected_bytes = {expected_bytes, enc(v, l)};
    endtask

    // queue the bytes one code unit turns into
    task automatic encode_unit(input logic [CU_W-1:0] cu);
        logic [BYTE_W-1:0] lo;
        lo = cu[BYTE_W-1:0];
        n_units++;
        if (cu != 0 && cu[CU_W-1:BYTE_W] == 0)
        begin
            if (passes_raw(lo))
            begin
                owe_byte(lo, 1'b1);
                n_raw++;
            end
            else
            begin
                // escape and two hex digits
                owe_byte(esc_model, 1'b0);
                owe_byte(hex_char(lo[7:4]), 1'b0);
                owe_byte(hex_char(lo[3:0]), 1'b1);
                n_short++;
            end
        end
        else
        begin
            // zero or wide unit: escape, 'x', four hex digits
            owe_byte(esc_model, 1'b0);
            owe_byte(CH_X, 1'b0);
            owe_byte(hex_char(cu[15:12]), 1'b0);
            owe_byte(hex_char(cu[11:8]), 1'b0);
            owe_byte(hex_char(cu[7:4]), 1'b0);
            owe_byte(hex_char(cu[3:0]), 1'b1);
            n_long++;
        end
    endtask

    // ---------------------------------------------------------------
    // monitor: samples all three channels at the rising edge
    // ---------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_model = ESCAPE_RESET;
            foreach (allow_model[w])
                allow_model[w] = MAP_NONE;
            unit_fire <= 1'b0;
        end
        else
        begin
            unit_fire <= unit_ch.valid && unit_ch.ready;

            // register writes only come while the encoder is idle
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                n_writes++;
                case (cfg_ch.index)
                    CFG_ESCAPE_BYTE:
                        esc_model = cfg_ch.data[BYTE_W-1:0];
                    CFG_ALLOW_MAP_0, CFG_ALLOW_MAP_1, CFG_ALLOW_MAP_2, CFG_ALLOW_MAP_3:
                        allow_model[2'(cfg_ch.index - CFG_ALLOW_MAP_0)] = cfg_ch.data;
                    default:
                        ; // unknown index, dropped
                endcase
            end

            if (unit_ch.valid && unit_ch.ready)
                encode_unit(unit_ch.code_unit);

            // input held back while the output is stalled
            if (unit_ch.valid && !unit_ch.ready && !byte_ch.ready)
                n_stalled++;

            if (byte_ch.valid && byte_ch.ready)
            begin
                n_bytes++;
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected byte %h last %b, nothing expected",
                             $time, byte_ch.out_byte, byte_ch.last_of_run);
                    n_errors++;
                end
                else
                begin
                    want_byte = expected_bytes.pop_front();
                    if (byte_ch.out_byte !== want_byte.value)
                    begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, want_byte.value, byte_ch.out_byte);
                        n_errors++;
                    end
                    if (byte_ch.last_of_run !== want_byte.is_last)
                    begin
                        $display("%0t: last_of_run expected %b actual %b",
                                 $time, want_byte.is_last, byte_ch.last_of_run);
                        n_errors++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // driver: offers queued code units at the falling edge
    // ---------------------------------------------------------------

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            unit_ch.valid     <= 1'b0;
            unit_ch.code_unit <= '0;
        end
        else if (!unit_ch.valid || unit_fire)
        begin
            // previous item gone (or none offered): next one or a gap
            if (unit_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                unit_ch.code_unit <= unit_queue.pop_front();
                unit_ch.valid     <= 1'b1;
            end
            else
                unit_ch.valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            byte_ch.ready <= 1'b0;
        else if (hold_asked != hold_taken)
        begin
            hold_taken    <= hold_asked;
            hold_left     <= HOLD_CYCLES;
            byte_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            byte_ch.ready <= 1'b0;
        end
        else
            byte_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // one register write; valid stays high into the next write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAP_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    task automatic load_settings(input logic [MAP_W-1:0] esc, input logic [MAP_W-1:0] m0,
                                 input logic [MAP_W-1:0] m1, input logic [MAP_W-1:0] m2,
                                 input logic [MAP_W-1:0] m3);
        write_reg(CFG_ESCAPE_BYTE, esc);
        write_reg(CFG_ALLOW_MAP_0, m0);
        write_reg(CFG_ALLOW_MAP_1, m1);
        write_reg(CFG_ALLOW_MAP_2, m2);
        write_reg(CFG_ALLOW_MAP_3, m3);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // wait until every offered unit went in and every byte came out
    task automatic wait_idle;
        while (unit_queue.size() != 0 || unit_ch.valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [MAP_W-1:0] rand_map();
        return {$urandom, $urandom};
    endfunction

    // mix of raw candidates, punctuation, edges and full-width units
    function automatic logic [CU_W-1:0] rand_unit();
        case ($urandom_range(0, 9))
            0, 1, 2: return CU_W'($urandom_range(1, 255));
            3:
            begin
                case ($urandom_range(0, 2))
                    0:       return CU_W'(CH_LOWER_A + $urandom_range(0, 25));
                    1:       return CU_W'(CH_UPPER_A + $urandom_range(0, 25));
                    default: return CU_W'(CH_DIGIT_0 + $urandom_range(0, 9));
                endcase
            end
            4: return CU_W'($urandom_range(16'h0020, 16'h002f));
            5:
            begin
                case ($urandom_range(0, 5))
                    0:       return 16'h0000;
                    1:       return 16'h00ff;
                    2:       return 16'h0100;
                    3:       return 16'hffff;
                    4:       return 16'h0080;
                    default: return 16'h007f;
                endcase
            end
            default: return CU_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic queue_random(input int count);
        repeat (count) unit_queue = {unit_queue, rand_unit()};
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_ESCAPE_BYTE;
        cfg_ch.data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: percent escape, empty allow map
        // zero, one, the edges of each character class, 0x7f/0x80, 0xff/0x100,
        // the top code unit, and the escape byte itself
        unit_queue = {16'h0000, 16'h0001, 16'h002f, 16'h0030, 16'h0039, 16'h0040,
                      16'h0041, 16'h005a, 16'h005b, 16'h0060, 16'h0061, 16'h007a,
                      16'h007b, 16'h007f, 16'h0080, 16'h00ff, 16'h0100, 16'hffff,
                      16'h0025};
        wait_idle();

        // unused indexes must be dropped; escape gets junk above its 8 bits;
        // escape is a letter and every byte is allowed
        write_reg(IDX_UNUSED_LO, MAP_ALL);
        write_reg(IDX_UNUSED_HI, MAP_ALL);
        load_settings({{(MAP_W - BYTE_W){1'b1}}, CH_UPPER_A}, MAP_ALL, MAP_ALL, MAP_ALL,
                      MAP_ALL);
        // zero still takes the long form though bit 0 is allowed
        unit_queue = {16'h0041, 16'h0000, 16'h0025, 16'h0080, 16'h00ff, 16'h01ff};
        wait_idle();

        // full speed, lowest escape byte, random maps; output held off long enough
        // that the run register fills and input backs up
        load_settings(MAP_NONE, rand_map(), rand_map(), rand_map(), rand_map());
        hold_asked = hold_asked + 1;
        queue_random(RANDOM_PER_PHASE);
        wait_idle();

        // sparse input
        send_idle_pct = 81;
        stall_pct     = 0;
        load_settings(MAP_W'($urandom_range(0, 255)), rand_map(), rand_map(), rand_map(),
                      rand_map());
        queue_random(RANDOM_PER_PHASE);
        wait_idle();

        // slow output, top escape byte, nothing allowed
        send_idle_pct = 0;
        stall_pct     = 81;
        load_settings(MAP_W'(8'hff), MAP_NONE, MAP_NONE, MAP_NONE, MAP_NONE);
        queue_random(RANDOM_PER_PHASE);
        wait_idle();

        // both sides idling
        send_idle_pct = 34;
        stall_pct     = 34;
        load_settings(MAP_W'($urandom_range(16'h21, 16'h7e)), rand_map(), rand_map(),
                      rand_map(), rand_map());
        queue_random(RANDOM_PER_PHASE);
        wait_idle();

        if (expected_bytes.size() != 0)
            $display("%0t: %0d bytes never arrived", $time, expected_bytes.size());

        $display("encoded %0d code units (%0d raw, %0d two-digit, %0d four-digit), %0d bytes",
                 n_units, n_raw, n_short, n_long, n_bytes);
        $display("%0d register writes over six settings, input backed up %0d cycles",
                 n_writes, n_stalled);
        if (n_errors == 0 && expected_bytes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
